[sv/adcs_pkg.sv]
package adcs_pkg;

	localparam int unsigned FIFO_DEPTH_DEF   = 1024;
	localparam int unsigned MAX_CHANNELS_DEF = 16;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CFG_W    = 5;
	localparam int unsigned SLOT_W   = 4;

	localparam logic [7:0]        CMD_START_BIT  = 8'h80;
	localparam logic [SLOT_W-1:0] SLOTS_PER_CONV = 4'd8;
	localparam logic [CFG_W-1:0]  ACTIVE_RESET   = 5'd8;

	typedef enum logic [1:0] {
		CMD_SCAN      = 2'd0,
		CMD_READ      = 2'd1,
		CMD_FLUSH     = 2'd2,
		CMD_FLUSH_ALL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_READ,
		OP_FLUSH,
		OP_FLUSH_ALL,
		OP_RANGE
	} op_kind_t;

	// classified command, front to back
	typedef struct packed {
		op_kind_t            kind;
		logic [SLOT_W-1:0]   channel;
		logic [SAMPLE_W-1:0] sample;
		logic [7:0]          tx_command;
		logic                chip_select;
		logic [SLOT_W-1:0]   dest_channel;
	} op_t;

	typedef struct packed {
		logic [7:0]          tx_command;
		logic                chip_select;
		logic [SLOT_W-1:0]   dest_channel;
		status_t             status;
		logic [SAMPLE_W-1:0] read_data;
	} res_t;

endpackage

[sv/adcs_ram.sv]
module adcs_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/adcs_front.sv]
module adcs_front import adcs_pkg::*; #(
	parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 cmd,
	input  logic [SLOT_W-1:0]          slot,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [SLOT_W-1:0]          channel,
	output logic                       op_valid,
	output op_t                        op,
	input  logic                       op_pop
);

	logic [CFG_W-1:0]  active_q;
	logic [CFG_W-1:0]  eff;
	logic [SLOT_W-1:0] dest;
	op_t               cls;

	op_t               q_op_q [2];
	logic              q_wr_q;
	logic              q_rd_q;
	logic [1:0]        q_cnt_q;
	logic              acc;

	always_comb begin
		if (active_q == '0)
			eff = CFG_W'(1);
		else if (active_q > CFG_W'(MAX_CHANNELS))
			eff = CFG_W'(MAX_CHANNELS);
		else
			eff = active_q;
	end

	// slot 0 wraps to min(7, last), slot 8 to the last
	always_comb begin
		if (slot == '0)
			dest = (eff >= CFG_W'(SLOTS_PER_CONV)) ? 4'd7 : SLOT_W'(eff - CFG_W'(1));
		else if (slot == SLOTS_PER_CONV)
			dest = SLOT_W'(eff - CFG_W'(1));
		else
			dest = slot - 4'd1;
	end

	always_comb begin
		cls = '0;
		cls.sample = sample;
		cls.channel = channel;
		cls.kind = OP_RANGE;
		unique case (cmd_t'(cmd))
			CMD_SCAN: begin
				cls.tx_command = CMD_START_BIT | {5'd0, slot[2:0]};
				cls.chip_select = slot[3];
				if ({1'b0, slot} < eff) begin
					cls.kind = OP_PUSH;
					cls.dest_channel = dest;
					cls.channel = dest;
				end
			end
			CMD_READ: begin
				if ({1'b0, channel} < eff)
					cls.kind = OP_READ;
			end
			CMD_FLUSH: begin
				if ({1'b0, channel} < eff)
					cls.kind = OP_FLUSH;
			end
			CMD_FLUSH_ALL: cls.kind = OP_FLUSH_ALL;
			default: cls.kind = OP_RANGE;
		endcase
	end

	assign full = (q_cnt_q == 2'd2);
	assign acc = push && !full;
	assign op_valid = (q_cnt_q != 2'd0);
	assign op = q_op_q[q_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
			q_wr_q <= 1'b0;
			q_rd_q <= 1'b0;
			q_cnt_q <= 2'd0;
		end else begin
			if (cfg_we)
				active_q <= cfg_wdata;
			if (acc)
				q_wr_q <= !q_wr_q;
			if (op_pop)
				q_rd_q <= !q_rd_q;
			q_cnt_q <= q_cnt_q + 2'(acc) - 2'(op_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			q_op_q[q_wr_q] <= cls;
	end

endmodule

[sv/adcs_back.sv]
module adcs_back import adcs_pkg::*; #(
	parameter int unsigned FIFO_DEPTH   = FIFO_DEPTH_DEF,
	parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	input  op_t                 op,
	output logic                op_pop,
	output logic                empty,
	input  logic                pop,
	output res_t                res
);

	localparam int unsigned PW    = $clog2(FIFO_DEPTH);
	localparam int unsigned CW    = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int unsigned WORDS = MAX_CHANNELS * FIFO_DEPTH;
	localparam int unsigned AW    = $clog2(WORDS);

	typedef enum logic {S_RUN, S_READ} state_t;

	state_t            st_q;
	logic [PW-1:0]     wp_q  [MAX_CHANNELS];
	logic [PW-1:0]     rp_q  [MAX_CHANNELS];
	logic [CW-1:0]     cnt_q [MAX_CHANNELS];
	res_t              pend_q;

	res_t              out_q [2];
	logic              out_wr_q;
	logic              out_rd_q;
	logic [1:0]        out_cnt_q;

	logic [CHW-1:0]      ch;
	logic [PW-1:0]       cur_wp;
	logic [PW-1:0]       cur_rp;
	logic [CW-1:0]       cur_cnt;
	logic                ch_full;
	logic [AW-1:0]       base;
	logic                start;
	logic                ram_we;
	logic                ram_re;
	logic [AW-1:0]       waddr;
	logic [AW-1:0]       raddr;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic                res_push;
	res_t                res_new;
	logic                out_pop;

	function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
		return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign ch      = op.channel[CHW-1:0];
	assign cur_wp  = wp_q[ch];
	assign cur_rp  = rp_q[ch];
	assign cur_cnt = cnt_q[ch];
	assign ch_full = (cur_cnt == CW'(FIFO_DEPTH));
	assign base    = AW'(ch) * AW'(FIFO_DEPTH);

	// one op at a time; the result queue only fills from here
	assign start  = op_valid && (st_q == S_RUN) && (out_cnt_q != 2'd2);
	assign op_pop = start;

	assign waddr  = base + (ch_full ? AW'(0) : AW'(cur_wp));
	assign raddr  = base + AW'(cur_rp);
	assign ram_we = start && (op.kind == OP_PUSH);
	assign ram_re = start && (op.kind == OP_READ) && (cur_cnt != '0);

	adcs_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(op.sample),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		res_new.tx_command   = op.tx_command;
		res_new.chip_select  = op.chip_select;
		res_new.dest_channel = op.dest_channel;
		res_new.read_data    = '0;
		res_new.status       = ST_OK;
		res_push             = 1'b0;
		if (st_q == S_READ) begin
			res_new = pend_q;
			res_new.read_data = ram_rdata;
			res_push = 1'b1;
		end else if (start) begin
			res_push = !ram_re;
			case (op.kind)
				OP_PUSH:  res_new.status = ch_full ? ST_OVERFLOW : ST_OK;
				OP_READ:  res_new.status = (cur_cnt == '0) ? ST_EMPTY : ST_OK;
				OP_RANGE: res_new.status = ST_RANGE;
				default:  res_new.status = ST_OK;
			endcase
		end
	end

	assign out_pop = pop && !empty;
	assign empty   = (out_cnt_q == 2'd0);
	assign res     = out_q[out_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_RUN;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				wp_q[i]  <= '0;
				rp_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (res_push)
				out_wr_q <= !out_wr_q;
			if (out_pop)
				out_rd_q <= !out_rd_q;
			out_cnt_q <= out_cnt_q + 2'(res_push) - 2'(out_pop);

			unique case (st_q)
				S_RUN: begin
					if (start) begin
						case (op.kind)
							OP_PUSH: begin
								if (ch_full) begin
									rp_q[ch]  <= '0;
									wp_q[ch]  <= next_pos('0);
									cnt_q[ch] <= CW'(1);
								end else begin
									wp_q[ch]  <= next_pos(cur_wp);
									cnt_q[ch] <= cur_cnt + CW'(1);
								end
							end
							OP_READ: begin
								if (cur_cnt != '0) begin
									rp_q[ch]  <= next_pos(cur_rp);
									cnt_q[ch] <= cur_cnt - CW'(1);
									st_q      <= S_READ;
								end
							end
							OP_FLUSH: begin
								wp_q[ch]  <= '0;
								rp_q[ch]  <= '0;
								cnt_q[ch] <= '0;
							end
							OP_FLUSH_ALL: begin
								for (int i = 0; i < MAX_CHANNELS; i++) begin
									wp_q[i]  <= '0;
									rp_q[i]  <= '0;
									cnt_q[i] <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: st_q <= S_RUN;
				default: st_q <= S_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && ram_re)
			pend_q <= res_new;
		if (res_push)
			out_q[out_wr_q] <= res_new;
	end

endmodule

[sv/adc_scan_sequencer_with_channel_fifos.sv]
// channel   direction  handshake          payload
// input     in         push / full        cmd, slot, sample, channel
// result    out        empty / pop        tx_command, chip_select, dest_channel, status,
//                                         read_data
// config    in         cfg_we             cfg_wdata (active_channels)
//
// The front classifies an item in the cycle it is taken and queues it (two entries).
// The back takes one queued item a cycle while the result queue has room; a read that returns a word
// holds it in a read state, set by the registered read port of the sample memory.
// Results wait in a two-entry queue; with pop low, full rises once four items are held.
// Reset clears the pointers and fill counts of every channel at once; the sample
// memory is not cleared and needs no pass after reset.
module adc_scan_sequencer_with_channel_fifos import adcs_pkg::*; #(
	parameter int unsigned FIFO_DEPTH   = FIFO_DEPTH_DEF,
	parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 cmd,
	input  logic [SLOT_W-1:0]          slot,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [SLOT_W-1:0]          channel,
	output logic                       empty,
	input  logic                       pop,
	output logic [7:0]                 tx_command,
	output logic                       chip_select,
	output logic [SLOT_W-1:0]          dest_channel,
	output logic [1:0]                 status,
	output logic signed [SAMPLE_W-1:0] read_data
);

	logic op_valid;
	logic op_pop;
	op_t  op;
	res_t res;

	adcs_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.slot     (slot),
		.sample   (sample),
		.channel  (channel),
		.op_valid (op_valid),
		.op       (op),
		.op_pop   (op_pop)
	);

	adcs_back #(
		.FIFO_DEPTH  (FIFO_DEPTH),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_valid(op_valid),
		.op      (op),
		.op_pop  (op_pop),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign tx_command   = res.tx_command;
	assign chip_select  = res.chip_select;
	assign dest_channel = res.dest_channel;
	assign status       = res.status;
	assign read_data    = res.read_data;

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> op_valid)
		else $error("back took an item from an empty command queue");

	a_cs_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && chip_select |-> tx_command[7])
		else $error("chip select on an item that was no scan");

	a_ovf_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (status == ST_OVERFLOW) |-> tx_command[7] && (read_data == '0))
		else $error("overflow reported on an item that was no scan");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb import adcs_pkg::*; ();

	localparam int unsigned DEPTH = FIFO_DEPTH_DEF;
	localparam int unsigned NCH   = MAX_CHANNELS_DEF;

	// mirror of the channel FIFOs plus the results they should produce, oldest first
	class channel_fifo_mirror;
		logic [SAMPLE_W-1:0] words [NCH][DEPTH];
		int unsigned         wr_ptr [NCH];
		int unsigned         rd_ptr [NCH];
		int unsigned         fill   [NCH];
		logic [CFG_W-1:0]    active_reg;
		res_t                pending_results [$];
		int                  errors;

		function new();
			active_reg = ACTIVE_RESET;
			errors = 0;
			for (int c = 0; c < NCH; c++)
				clear_channel(c);
		endfunction

		function void clear_channel(int unsigned c);
			wr_ptr[c] = 0;
			rd_ptr[c] = 0;
			fill[c] = 0;
		endfunction

		function void set_active(logic [CFG_W-1:0] v);
			active_reg = v;
		endfunction

		// register saturated to 1..NCH
		function int unsigned active_count();
			if (active_reg == 0)
				return 1;
			if (active_reg > NCH)
				return NCH;
			return 32'(active_reg);
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void take_item(cmd_t op, logic [SLOT_W-1:0] s, logic [SAMPLE_W-1:0] smp,
				logic [SLOT_W-1:0] ch);
			res_t        r;
			int unsigned n;
			int unsigned d;
			r = '0;
			n = active_count();
			case (op)
				CMD_SCAN: begin
					r.tx_command = CMD_START_BIT | {5'd0, s[2:0]};
					r.chip_select = (s >= SLOTS_PER_CONV);
					if (s >= n) begin
						r.status = ST_RANGE;
					end else begin
						if (s == 0)
							d = (n >= SLOTS_PER_CONV) ? SLOTS_PER_CONV - 1 : n - 1;
						else if (s == SLOTS_PER_CONV)
							d = n - 1;
						else
							d = s - 1;
						r.dest_channel = d[SLOT_W-1:0];
						r.status = ST_OK;
						if (fill[d] >= DEPTH) begin
							clear_channel(d);
							r.status = ST_OVERFLOW;
						end
						words[d][wr_ptr[d]] = smp;
						wr_ptr[d] = (wr_ptr[d] + 1) % DEPTH;
						fill[d]++;
					end
				end
				CMD_READ: begin
					if (ch >= n) begin
						r.status = ST_RANGE;
					end else if (fill[ch] == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.status = ST_OK;
						r.read_data = words[ch][rd_ptr[ch]];
						rd_ptr[ch] = (rd_ptr[ch] + 1) % DEPTH;
						fill[ch]--;
					end
				end
				CMD_FLUSH: begin
					if (ch >= n) begin
						r.status = ST_RANGE;
					end else begin
						r.status = ST_OK;
						clear_channel(ch);
					end
				end
				default: begin
					// clears inactive channels as well
					r.status = ST_OK;
					for (int c = 0; c < NCH; c++)
						clear_channel(c);
				end
			endcase
			pending_results.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task match_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing outstanding: %p", got));
				return;
			end
			want = pending_results.pop_front();
			if (got.tx_command !== want.tx_command)
				report($sformatf("tx_command %h, want %h", got.tx_command, want.tx_command));
			if (got.chip_select !== want.chip_select)
				report($sformatf("chip_select %b, want %b", got.chip_select, want.chip_select));
			if (got.dest_channel !== want.dest_channel)
				report($sformatf("dest_channel %0d, want %0d", got.dest_channel,
					want.dest_channel));
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.read_data !== want.read_data)
				report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_W-1:0]           cfg_wdata;
	logic                       push;
	logic                       full;
	logic [1:0]                 cmd;
	logic [SLOT_W-1:0]          slot;
	logic signed [SAMPLE_W-1:0] sample;
	logic [SLOT_W-1:0]          channel;
	logic                       empty;
	logic                       pop;
	logic [7:0]                 tx_command;
	logic                       chip_select;
	logic [SLOT_W-1:0]          dest_channel;
	logic [1:0]                 status;
	logic signed [SAMPLE_W-1:0] read_data;

	channel_fifo_mirror mirror;
	int tx_idle_pct;
	int rx_stall_pct;
	int rx_hold_left;

	adc_scan_sequencer_with_channel_fifos dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.slot         (slot),
		.sample       (sample),
		.channel      (channel),
		.empty        (empty),
		.pop          (pop),
		.tx_command   (tx_command),
		.chip_select  (chip_select),
		.dest_channel (dest_channel),
		.status       (status),
		.read_data    (read_data)
	);

	always #1 clk = ~clk;

	task automatic send_item(cmd_t op, logic [SLOT_W-1:0] s, logic [SAMPLE_W-1:0] smp,
			logic [SLOT_W-1:0] ch);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		cmd <= op;
		slot <= s;
		sample <= smp;
		channel <= ch;
		do @(posedge clk); while (full);
		mirror.take_item(op, s, smp, ch);
	endtask

	// stop offering items until every outstanding result has been taken
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (mirror.pending() != 0);
	endtask

	task automatic set_active(logic [CFG_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.set_active(v);
	endtask

	task automatic send_random(int unsigned n);
		int unsigned       pick;
		int unsigned       cnt;
		cmd_t              op;
		logic [SLOT_W-1:0] s;
		logic [SLOT_W-1:0] ch;
		repeat (n) begin
			cnt = mirror.active_count();
			pick = $urandom_range(99);
			if (pick < 55)
				op = CMD_SCAN;
			else if (pick < 88)
				op = CMD_READ;
			else if (pick < 98)
				op = CMD_FLUSH;
			else
				op = CMD_FLUSH_ALL;
			// mostly in range, now and then anything the field allows
			s = SLOT_W'(($urandom_range(9) == 0) ? $urandom_range(15)
				: $urandom_range(cnt - 1));
			ch = SLOT_W'(($urandom_range(9) == 0) ? $urandom_range(15)
				: $urandom_range(cnt - 1));
			send_item(op, s, SAMPLE_W'($urandom), ch);
		end
	endtask

	initial begin : result_monitor
		res_t got;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.tx_command = tx_command;
				got.chip_select = chip_select;
				got.dest_channel = dest_channel;
				got.status = status_t'(status);
				got.read_data = read_data;
				mirror.match_result(got);
			end
			if (rx_hold_left > 0) begin
				pop <= 1'b0;
				rx_hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin : stimulus
		int unsigned      tgt;
		int unsigned      tslot;
		logic [CFG_W-1:0] phase_cfg [4];
		int               phase_tx [4];
		int               phase_rx [4];
		mirror = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		push = 1'b0;
		cmd = CMD_SCAN;
		slot = '0;
		sample = '0;
		channel = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: eight channels
		send_item(CMD_SCAN, 4'd0, 16'h7FFF, 4'd0);
		send_item(CMD_SCAN, 4'd1, 16'h8000, 4'hF);
		send_item(CMD_SCAN, 4'd7, 16'h0000, 4'd0);
		send_item(CMD_SCAN, 4'd8, 16'hFFFF, 4'd0);
		send_item(CMD_READ, 4'd0, 16'h0000, 4'd7);
		send_item(CMD_READ, 4'hF, 16'hFFFF, 4'd7);
		send_item(CMD_READ, 4'd0, 16'h0000, 4'd0);
		send_item(CMD_READ, 4'd0, 16'h0000, 4'd8);
		send_item(CMD_SCAN, 4'd2, 16'h1234, 4'd0);
		send_item(CMD_FLUSH, 4'd0, 16'h0000, 4'd1);
		send_item(CMD_READ, 4'd0, 16'h0000, 4'd1);
		send_item(CMD_FLUSH, 4'd0, 16'h0000, 4'hF);
		send_item(CMD_FLUSH_ALL, 4'd0, 16'h0000, 4'd0);
		send_item(CMD_READ, 4'd0, 16'h0000, 4'd6);

		// slot 8 wraps to the last channel
		set_active(5'd16);
		send_item(CMD_SCAN, 4'd8, 16'hA5A5, 4'd0);
		send_item(CMD_SCAN, 4'd0, 16'h0001, 4'd0);
		send_item(CMD_SCAN, 4'hF, 16'h4000, 4'd0);
		send_item(CMD_FLUSH, 4'd0, 16'h0000, 4'hE);

		set_active(5'd1);
		send_item(CMD_SCAN, 4'd0, 16'h00FF, 4'd0);
		send_item(CMD_SCAN, 4'd1, 16'hFF00, 4'd0);
		send_item(CMD_READ, 4'd0, 16'h0000, 4'd1);

		// out-of-range register values saturate
		set_active(5'd0);
		send_item(CMD_SCAN, 4'd0, 16'h0F0F, 4'd0);
		set_active(5'd31);
		send_item(CMD_READ, 4'd0, 16'h0000, 4'hF);
		send_item(CMD_SCAN, 4'd8, 16'h3C3C, 4'd0);

		set_active(5'd3);
		send_item(CMD_SCAN, 4'd0, 16'hC3C3, 4'd0);
		send_item(CMD_SCAN, 4'd8, 16'h0000, 4'd0);

		// flush all must reach channels that are not active
		set_active(5'd8);
		send_item(CMD_FLUSH_ALL, 4'd0, 16'h0000, 4'd0);

		phase_cfg[0] = 5'd16;
		phase_cfg[1] = 5'd3;
		phase_cfg[2] = CFG_W'($urandom_range(31));
		phase_cfg[3] = 5'd8;
		phase_tx[0] = 0;  phase_rx[0] = 0;
		phase_tx[1] = 46; phase_rx[1] = 0;
		phase_tx[2] = 0;  phase_rx[2] = 46;
		phase_tx[3] = 10; phase_rx[3] = 10;
		for (int p = 0; p < 4; p++) begin
			set_active(phase_cfg[p]);
			tx_idle_pct = phase_tx[p];
			rx_stall_pct = phase_rx[p];
			if (p == 0) begin
				send_item(CMD_READ, 4'd0, 16'h0000, 4'hF);
				send_random(30);
				// long receiver hold-off: the block fills and stalls its input
				rx_hold_left = 300;
				send_random(30);
				drain();
				send_random(20);
			end else begin
				send_random(60);
			end
		end

		// one channel filled until the pointers meet, read, refilled, then an overflow
		set_active(5'd16);
		send_item(CMD_FLUSH_ALL, 4'd0, 16'h0000, 4'd0);
		tgt = $urandom_range(NCH - 1);
		if (tgt == SLOTS_PER_CONV - 1)
			tslot = 0;
		else if (tgt == NCH - 1)
			tslot = SLOTS_PER_CONV;
		else
			tslot = tgt + 1;
		repeat (DEPTH)
			send_item(CMD_SCAN, SLOT_W'(tslot), SAMPLE_W'($urandom), SLOT_W'($urandom));
		repeat (2)
			send_item(CMD_READ, SLOT_W'($urandom), SAMPLE_W'($urandom), SLOT_W'(tgt));
		repeat (3)
			send_item(CMD_SCAN, SLOT_W'(tslot), SAMPLE_W'($urandom), SLOT_W'($urandom));
		repeat (2)
			send_item(CMD_READ, SLOT_W'($urandom), SAMPLE_W'($urandom), SLOT_W'(tgt));

		drain();
		repeat (20) @(posedge clk);
		if (mirror.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
